FILE: design/shrb_pkg.sv
// ----------------------------------------------------------------------------
// shrb_pkg
// Shared constants and types of the SPI host register block: word map,
// reset values and the receive FIFO control group.
// ----------------------------------------------------------------------------
package shrb_pkg;

	localparam int NumCsDefault     = 1;
	localparam int FifoDepthDefault = 8;
	localparam int RegWords         = 30;
	localparam int AddrW            = 10;

	localparam logic ReqRead  = 1'b0;
	localparam logic ReqWrite = 1'b1;

	localparam logic [AddrW-1:0] WSckdiv  = 10'd0;
	localparam logic [AddrW-1:0] WSckmode = 10'd1;
	localparam logic [AddrW-1:0] WCsid    = 10'd4;
	localparam logic [AddrW-1:0] WCsdef   = 10'd5;
	localparam logic [AddrW-1:0] WCsmode  = 10'd6;
	localparam logic [AddrW-1:0] WDelay0  = 10'd10;
	localparam logic [AddrW-1:0] WDelay1  = 10'd11;
	localparam logic [AddrW-1:0] WFmt     = 10'd16;
	localparam logic [AddrW-1:0] WTxdata  = 10'd18;
	localparam logic [AddrW-1:0] WRxdata  = 10'd19;
	localparam logic [AddrW-1:0] WTxmark  = 10'd20;
	localparam logic [AddrW-1:0] WRxmark  = 10'd21;
	localparam logic [AddrW-1:0] WFctrl   = 10'd24;
	localparam logic [AddrW-1:0] WFfmt    = 10'd25;
	localparam logic [AddrW-1:0] WIe      = 10'd28;
	localparam logic [AddrW-1:0] WIp      = 10'd29;

	localparam logic [AddrW-1:0] WRsv2  = 10'd2;
	localparam logic [AddrW-1:0] WRsv3  = 10'd3;
	localparam logic [AddrW-1:0] WRsv7  = 10'd7;
	localparam logic [AddrW-1:0] WRsv8  = 10'd8;
	localparam logic [AddrW-1:0] WRsv9  = 10'd9;
	localparam logic [AddrW-1:0] WRsv12 = 10'd12;
	localparam logic [AddrW-1:0] WRsv13 = 10'd13;
	localparam logic [AddrW-1:0] WRsv14 = 10'd14;
	localparam logic [AddrW-1:0] WRsv15 = 10'd15;
	localparam logic [AddrW-1:0] WRsv17 = 10'd17;
	localparam logic [AddrW-1:0] WRsv22 = 10'd22;
	localparam logic [AddrW-1:0] WRsv23 = 10'd23;
	localparam logic [AddrW-1:0] WRsv26 = 10'd26;
	localparam logic [AddrW-1:0] WRsv27 = 10'd27;

	localparam logic [31:0] SckdivRst = 32'h0000_0003;
	localparam logic [31:0] Delay0Rst = 32'h0000_1001;
	localparam logic [31:0] Delay1Rst = 32'h0000_0001;
	localparam logic [31:0] EmptyFlag = 32'h8000_0000;
	localparam int          DirBit    = 3;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctrl_t;

endpackage

FILE: design/spi_host_register_block_top.sv
// ----------------------------------------------------------------------------
// spi_host_register_block_top
// Register block of a SPI host: register file, receive FIFO, chip selects.
// ----------------------------------------------------------------------------
// Each word is one aligned 32-bit register access. A word passes an input
// register, is decoded and applied to the register file and receive FIFO,
// and its result lands in an output register. A new word can be taken
// every cycle, one word per cycle, held back only by out_ready. A transmit
// data write reports the sent byte at once and queues the returned byte
// unless the FIFO is full or the fmt direction bit is set. The receive FIFO is
// a memory with a registered head read, so there is no clearing pass after reset.
module spi_host_register_block_top #(
	parameter int NUM_CS     = shrb_pkg::NumCsDefault,
	parameter int FIFO_DEPTH = shrb_pkg::FifoDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [9:0]  word_addr,
	input  logic [31:0] wdata,
	input  logic [7:0]  miso_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] rdata,
	output logic        irq_level,
	output logic        cs_levels,
	output logic        spi_send_valid,
	output logic [7:0]  spi_send_byte,
	output logic        bad_access
);

	localparam int CW     = $clog2(FIFO_DEPTH + 1);
	localparam int MarkW  = $clog2(FIFO_DEPTH);
	localparam int CsIdW  = (NUM_CS > 1) ? $clog2(NUM_CS) : 1;

	// input stage
	logic        valid_s1;
	logic        req_type_s1;
	logic [9:0]  word_addr_s1;
	logic [31:0] wdata_s1;
	logic [7:0]  miso_byte_s1;

	// registers
	logic [31:0]       sckdiv_q;
	logic [31:0]       sckmode_q;
	logic [CsIdW-1:0]  csid_q;
	logic [NUM_CS-1:0] csdef_q;
	logic [1:0]        csmode_q;
	logic [31:0]       delay0_q;
	logic [31:0]       delay1_q;
	logic [31:0]       fmt_q;
	logic [MarkW-1:0]  txmark_q;
	logic [MarkW-1:0]  rxmark_q;
	logic [31:0]       ie_q;
	logic [NUM_CS-1:0] cs_q;

	// result stage
	logic        out_valid_q;
	logic [31:0] rdata_q;
	logic        irq_q;
	logic        cs_level_q;
	logic        sent_q;
	logic [7:0]  sbyte_q;
	logic        bad_q;

	logic                 adv;
	shrb_pkg::fifo_ctrl_t fifo_ctrl;
	logic [CW-1:0]        rx_count;
	logic [7:0]           rx_head_data;

	logic [31:0]       rdata_d;
	logic              bad_d;
	logic              sent_d;
	logic              push_d;
	logic              pop_d;
	logic              sckdiv_we, sckmode_we, csid_we, csdef_we, csmode_we;
	logic              delay0_we, delay1_we, fmt_we, txmark_we, rxmark_we, ie_we;
	logic              txwm, rxwm;
	logic              csid_ok, csdef_ok, csmode_ok, mark_ok;
	logic [MarkW-1:0]  txmark_d;
	logic [MarkW-1:0]  rxmark_d;
	logic [31:0]       ie_d;
	logic [1:0]        csmode_d;
	logic [NUM_CS-1:0] cs_d;
	logic [CW-1:0]     count_d;
	logic              irq_d;
	logic [32:0]       wdata_x;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1  <= req_type;
			word_addr_s1 <= word_addr;
			wdata_s1     <= wdata;
			miso_byte_s1 <= miso_byte;
		end
	end

	// watermark pending bits from current state
	assign txwm    = (txmark_q != '0);
	assign rxwm    = (rx_count > CW'(rxmark_q));
	assign wdata_x = {1'b0, wdata_s1};

	assign csid_ok   = (wdata_x < 33'(NUM_CS));
	assign csdef_ok  = ((wdata_x >> NUM_CS) == '0);
	assign csmode_ok = (wdata_s1[31:2] == '0);
	assign mark_ok   = (wdata_x < 33'(FIFO_DEPTH));

	always_comb begin
		rdata_d    = '0;
		bad_d      = 1'b0;
		sent_d     = 1'b0;
		push_d     = 1'b0;
		pop_d      = 1'b0;
		sckdiv_we  = 1'b0;
		sckmode_we = 1'b0;
		csid_we    = 1'b0;
		csdef_we   = 1'b0;
		csmode_we  = 1'b0;
		delay0_we  = 1'b0;
		delay1_we  = 1'b0;
		fmt_we     = 1'b0;
		txmark_we  = 1'b0;
		rxmark_we  = 1'b0;
		ie_we      = 1'b0;
		if (req_type_s1 == shrb_pkg::ReqRead) begin
			unique case (word_addr_s1)
				shrb_pkg::WSckdiv:  rdata_d = sckdiv_q;
				shrb_pkg::WSckmode: rdata_d = sckmode_q;
				shrb_pkg::WCsid:    rdata_d = 32'(csid_q);
				shrb_pkg::WCsdef:   rdata_d = 32'(csdef_q);
				shrb_pkg::WCsmode:  rdata_d = 32'(csmode_q);
				shrb_pkg::WDelay0:  rdata_d = delay0_q;
				shrb_pkg::WDelay1:  rdata_d = delay1_q;
				shrb_pkg::WFmt:     rdata_d = fmt_q;
				shrb_pkg::WTxmark:  rdata_d = 32'(txmark_q);
				shrb_pkg::WRxmark:  rdata_d = 32'(rxmark_q);
				shrb_pkg::WIe:      rdata_d = ie_q;
				shrb_pkg::WIp:      rdata_d = {30'b0, rxwm, txwm};
				shrb_pkg::WRxdata: begin
					if (rx_count == '0) begin
						rdata_d = shrb_pkg::EmptyFlag;
					end else begin
						rdata_d = {24'b0, rx_head_data};
						pop_d   = 1'b1;
					end
				end
				default: begin
					rdata_d = '0;
					bad_d   = (word_addr_s1 >= 10'(shrb_pkg::RegWords));
				end
			endcase
		end else begin
			unique case (word_addr_s1) inside
				shrb_pkg::WSckdiv:  sckdiv_we  = 1'b1;
				shrb_pkg::WSckmode: sckmode_we = 1'b1;
				shrb_pkg::WDelay0:  delay0_we  = 1'b1;
				shrb_pkg::WDelay1:  delay1_we  = 1'b1;
				shrb_pkg::WFmt:     fmt_we     = 1'b1;
				shrb_pkg::WIe:      ie_we      = 1'b1;
				shrb_pkg::WCsid: begin
					csid_we = csid_ok;
					bad_d   = !csid_ok;
				end
				shrb_pkg::WCsdef: begin
					csdef_we = csdef_ok;
					bad_d    = !csdef_ok;
				end
				shrb_pkg::WCsmode: begin
					csmode_we = csmode_ok;
					bad_d     = !csmode_ok;
				end
				shrb_pkg::WTxmark: begin
					txmark_we = mark_ok;
					bad_d     = !mark_ok;
				end
				shrb_pkg::WRxmark: begin
					rxmark_we = mark_ok;
					bad_d     = !mark_ok;
				end
				shrb_pkg::WTxdata: begin
					sent_d = 1'b1;
					push_d = (rx_count != CW'(FIFO_DEPTH)) && !fmt_q[shrb_pkg::DirBit];
				end
				default: bad_d = 1'b1;
			endcase
		end
	end

	assign fifo_ctrl.push = adv && push_d;
	assign fifo_ctrl.pop  = adv && pop_d;

	shrb_rx_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_rx_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fifo_ctrl),
		.push_data (miso_byte_s1),
		.count     (rx_count),
		.head_data (rx_head_data)
	);

	// state after this word
	always_comb begin
		txmark_d = txmark_we ? wdata_s1[MarkW-1:0] : txmark_q;
		rxmark_d = rxmark_we ? wdata_s1[MarkW-1:0] : rxmark_q;
		ie_d     = ie_we ? wdata_s1 : ie_q;
		csmode_d = csmode_we ? wdata_s1[1:0] : csmode_q;
		if (push_d) begin
			count_d = rx_count + CW'(1);
		end else if (pop_d) begin
			count_d = rx_count - CW'(1);
		end else begin
			count_d = rx_count;
		end
		if (csid_we || csmode_we) begin
			cs_d = (cs_q & ~csdef_q) | (csdef_q & {NUM_CS{csmode_d == 2'd0}});
		end else begin
			cs_d = cs_q;
		end
		irq_d = ((txmark_d != '0) && ie_d[0]) || ((count_d > CW'(rxmark_d)) && ie_d[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sckdiv_q  <= shrb_pkg::SckdivRst;
			sckmode_q <= '0;
			csid_q    <= '0;
			csdef_q   <= '1;
			csmode_q  <= '0;
			delay0_q  <= shrb_pkg::Delay0Rst;
			delay1_q  <= shrb_pkg::Delay1Rst;
			fmt_q     <= '0;
			txmark_q  <= '0;
			rxmark_q  <= '0;
			ie_q      <= '0;
			cs_q      <= '1;
		end else if (adv) begin
			if (sckdiv_we) begin
				sckdiv_q <= wdata_s1;
			end
			if (sckmode_we) begin
				sckmode_q <= wdata_s1;
			end
			if (csid_we) begin
				csid_q <= wdata_s1[CsIdW-1:0];
			end
			if (csdef_we) begin
				csdef_q <= wdata_s1[NUM_CS-1:0];
			end
			if (delay0_we) begin
				delay0_q <= wdata_s1;
			end
			if (delay1_we) begin
				delay1_q <= wdata_s1;
			end
			if (fmt_we) begin
				fmt_q <= wdata_s1;
			end
			csmode_q <= csmode_d;
			txmark_q <= txmark_d;
			rxmark_q <= rxmark_d;
			ie_q     <= ie_d;
			cs_q     <= cs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q    <= rdata_d;
			irq_q      <= irq_d;
			cs_level_q <= cs_d[0];
			sent_q     <= sent_d;
			sbyte_q    <= sent_d ? wdata_s1[7:0] : 8'd0;
			bad_q      <= bad_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign rdata          = rdata_q;
	assign irq_level      = irq_q;
	assign cs_levels      = cs_level_q;
	assign spi_send_valid = sent_q;
	assign spi_send_byte  = sbyte_q;
	assign bad_access     = bad_q;

endmodule

FILE: design/shrb_rx_fifo.sv
// ----------------------------------------------------------------------------
// shrb_rx_fifo
// Receive FIFO: circular byte store with head and count, and a registered
// read port that always holds the word at the head.
// ----------------------------------------------------------------------------
module shrb_rx_fifo #(
	parameter int FIFO_DEPTH = shrb_pkg::FifoDepthDefault,
	localparam int AW = $clog2(FIFO_DEPTH),
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shrb_pkg::fifo_ctrl_t ctrl,
	input  logic [7:0]           push_data,
	output logic [CW-1:0]        count,
	output logic [7:0]           head_data
);

	localparam int SW = CW + 1;

	logic [7:0]    mem_q [FIFO_DEPTH];
	logic [7:0]    rd_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_q;
	logic [SW-1:0] wsum;
	logic [SW-1:0] wsum_wrap;
	logic [AW-1:0] waddr;

	always_comb begin
		wsum      = SW'(head_q) + SW'(count_q);
		wsum_wrap = (wsum >= SW'(FIFO_DEPTH)) ? wsum - SW'(FIFO_DEPTH) : wsum;
		waddr     = wsum_wrap[AW-1:0];
		if (ctrl.pop) begin
			head_d = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
		end else begin
			head_d = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			if (ctrl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[waddr] <= push_data;
		end
	end

	// head slot written this cycle only when the fifo was empty or a pop empties it
	always_ff @(posedge clk) begin
		if (ctrl.push && (waddr == head_d)) begin
			rd_q <= push_data;
		end else begin
			rd_q <= mem_q[head_d];
		end
	end

	assign count     = count_q;
	assign head_data = rd_q;

endmodule
